[rtl/srs_pkg.sv]
package srs_pkg;

  // Controller states, one-hot
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CHK  = 9'b000000010,
    S_CONV = 9'b000000100,
    S_UPD  = 9'b000001000,
    S_ACC  = 9'b000010000,
    S_RD   = 9'b000100000,
    S_RDW  = 9'b001000000,
    S_DIVQ = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;
    logic chk;
    logic conv_start;
    logic upd;
    logic acc;
    logic rd;
    logic q_start;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic       is_score;
    logic       need_conv;
    logic       can_read;
    logic       div_done;
    logic       div_busy;
    logic       out_full;
    logic [1:0] pending;
  } stat_t;

  localparam int          VT_WIDTH  = 7;
  localparam logic [6:0]  VT_RESET  = 7'd64;
  localparam logic        ADDR_VT   = 1'b0;
  localparam int          EXP_LOW   = -4080;
  localparam logic [63:0] EXP_STEP  = 64'd4034748382;

  typedef logic [15:0] rom_t [256];

  // Build exp(-i/16) in Q8.8 from the fixed-point recurrence
  function automatic rom_t build_exp_rom();
    rom_t         r;
    logic [127:0] a;
    logic [127:0] t;
    a = 128'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      t    = (a + (128'd1 << 23)) >> 24;
      r[i] = t[15:0];
      a    = (a * {64'd0, EXP_STEP} + (128'd1 << 31)) >> 32;
    end
    return r;
  endfunction

  localparam rom_t EXP_ROM = build_exp_rom();

endpackage

[rtl/srs_ram.sv]
module srs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/srs_div.sv]
module srs_div #(
  parameter int NW = 23,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          busy,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [CW-1:0] cnt;
  logic [DW:0]   shl;
  logic [DW:0]   dif;
  logic          ge;

  // One restoring step per cycle
  assign shl = {rem, quo[NW-1]};
  assign dif = shl - {1'b0, dreg};
  assign ge  = shl >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load operands, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num;
      dreg <= den;
      rem  <= '0;
    end else if (busy) begin
      quo <= {quo[NW-2:0], ge};
      rem <= ge ? dif[DW-1:0] : shl[DW-1:0];
    end
  end

endmodule

[rtl/srs_ctrl.sv]
module srs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  srs_pkg::stat_t stat,
  output srs_pkg::cmd_t  cmd
);

  import srs_pkg::*;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Sequence one request through check, optional convert and update, then read, divide and emit when a row waits
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (!stat.is_score) begin
          state_next = stat.can_read ? S_RD : S_IDLE;
        end else if (stat.need_conv) begin
          cmd.conv_start = 1'b1;
          state_next     = S_CONV;
        end else begin
          state_next = S_UPD;
        end
      end
      S_CONV: begin
        if (stat.div_done) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = stat.can_read ? S_RD : S_IDLE;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_RDW;
      end
      S_RDW: begin
        cmd.q_start = 1'b1;
        state_next  = S_DIVQ;
      end
      S_DIVQ: begin
        if (stat.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!stat.out_full) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/srs_dp.sv]
module srs_dp #(
  parameter int ROW_LEN   = 64,
  parameter int SCORE_DIV = 8,
  parameter int FIX_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  srs_pkg::cmd_t          cmd,
  output srs_pkg::stat_t         stat,
  input  logic                   op,
  input  logic [31:0]            score_bits,
  input  logic [6:0]             valid_tokens,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            prob_bits,
  output logic                   last_in_row
);

  import srs_pkg::*;

  localparam int FW   = FIX_WIDTH;
  localparam int NW   = FW + 7;
  localparam int PW   = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
  localparam int DW   = (FW + 1 > 14) ? FW + 1 : 14;
  localparam int CW   = (PW > 7) ? PW : 7;
  localparam int AW   = PW + 1;
  localparam int CVW  = FW + 6;
  localparam int NCH  = (CVW + 15) / 16;
  localparam int PADW = NCH * 16;

  localparam logic signed [FW-1:0] FMAX  = {1'b0, {(FW-1){1'b1}}};
  localparam logic signed [FW-1:0] FMIN  = {1'b1, {(FW-1){1'b0}}};
  localparam logic signed [FW-1:0] MASKV = (FW < 16) ? FMIN : FW'(-32768);
  localparam logic [NW-1:0]        QMAX  = {{(NW-FW+1){1'b0}}, {(FW-1){1'b1}}};
  localparam logic [NW-1:0]        QMIN  = QMAX + 1'b1;
  localparam logic [PW-1:0]        LASTP = PW'(ROW_LEN - 1);
  localparam logic [28:0]          RECIP =
    29'(((64'd1 << 28) + 64'(SCORE_DIV) - 64'd1) / 64'(SCORE_DIV));

  // Table exponential of a non-positive difference
  function automatic logic [8:0] exp_of(input logic signed [DW-1:0] d);
    logic [DW-1:0] nd;
    logic [15:0]   v;
    nd = -d;
    if (d < DW'(EXP_LOW)) begin
      v = EXP_ROM[255];
    end else if (d >= 0) begin
      v = EXP_ROM[0];
    end else begin
      v = EXP_ROM[nd[11:4]];
    end
    return v[8:0];
  endfunction

  // Captured request
  logic        op_r;
  logic [31:0] bits_r;
  logic        can_read_r;
  logic        masked_r;

  // Row state
  logic signed [FW-1:0] x;
  logic signed [FW-1:0] rmax;
  logic [FW-1:0]        rsum;
  logic [PW-1:0]        wpos;
  logic [PW-1:0]        rpos;
  logic                 wbank;
  logic                 rbank;
  logic [1:0]           pending;
  logic signed [FW-1:0] row_max [2];
  logic [FW-1:0]        row_sum [2];
  logic [FW+8:0]        prod;
  logic [8:0]           ev;

  // Score decode
  logic [7:0]        fe;
  logic [22:0]       ff;
  logic              nan;
  logic              inf;
  logic [23:0]       m;
  logic signed [9:0] shv;
  logic [9:0]        shk;
  logic [NW+23:0]    vw;
  logic              big;
  logic [CVW-1:0]    conv_num;

  assign fe  = bits_r[30:23];
  assign ff  = bits_r[22:0];
  assign nan = (fe == 8'hff) && (ff != '0);
  assign inf = (fe == 8'hff) && (ff == '0);
  assign m   = {fe != 8'd0, ff};
  assign shv = $signed({2'b00, (fe != 8'd0) ? fe : 8'd1}) - 10'sd142;
  assign shk = -shv;

  // Align mantissa to an integer, clip magnitudes that saturate anyway
  always_comb begin
    vw  = '0;
    big = inf;
    if (m != '0) begin
      if (!shv[9]) begin
        if (int'(shv) >= NW) begin
          big = 1'b1;
        end else begin
          vw = {{NW{1'b0}}, m} << shv[8:0];
        end
      end else if (shk < 10'd24) begin
        vw = {{NW{1'b0}}, m} >> shk;
      end
    end
    if (|vw[NW+23:NW]) begin
      big = 1'b1;
    end
    conv_num = (big || (|vw[NW+23:CVW])) ? {CVW{1'b1}} : vw[CVW-1:0];
  end

  // Divide the aligned score by SCORE_DIV, sixteen bits a cycle by reciprocal
  logic [PADW-1:0] cv_sh;
  logic [PADW-1:0] cv_quo;
  logic [5:0]      cv_rem;
  logic [1:0]      cv_cnt;
  logic            cv_busy;
  logic            cv_done;
  logic [21:0]     cv_t;
  logic [50:0]     cv_prod;
  logic [15:0]     cv_qd;
  logic [21:0]     cv_r;

  assign cv_t    = {cv_rem, cv_sh[PADW-1 -: 16]};
  assign cv_prod = 51'(cv_t) * 51'(RECIP);
  assign cv_qd   = cv_prod[43:28];
  assign cv_r    = cv_t - 22'(cv_qd) * 22'(SCORE_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_busy <= 1'b0;
      cv_done <= 1'b0;
      cv_cnt  <= '0;
    end else begin
      cv_done <= 1'b0;
      if (cmd.conv_start) begin
        cv_busy <= 1'b1;
        cv_cnt  <= 2'(NCH);
      end else if (cv_busy) begin
        cv_cnt <= cv_cnt - 2'd1;
        if (cv_cnt == 2'd1) begin
          cv_busy <= 1'b0;
          cv_done <= 1'b1;
        end
      end
    end
  end

  // Load the score, then shift out one quotient digit per cycle
  always_ff @(posedge clk) begin
    if (cmd.conv_start) begin
      cv_sh  <= PADW'(conv_num);
      cv_quo <= '0;
      cv_rem <= '0;
    end else if (cv_busy) begin
      cv_sh  <= cv_sh << 16;
      cv_quo <= (cv_quo << 16) | PADW'(cv_qd);
      cv_rem <= cv_r[5:0];
    end
  end

  // Probability divider
  logic [NW-1:0] div_q;
  logic          div_busy;
  logic          div_done;
  logic [NW-1:0] div_num;
  logic [FW-1:0] div_den;
  logic [FW-1:0] rdata;
  logic [8:0]    e_rd;
  logic signed [DW-1:0] d_rd;

  assign d_rd    = DW'(signed'(rdata)) - DW'(row_max[rbank]);
  assign e_rd    = exp_of(d_rd);
  assign div_num = NW'({e_rd, 8'h00});
  assign div_den = row_sum[rbank];

  srs_div #(.NW(NW), .DW(FW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.q_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .busy  (div_busy),
    .done  (div_done)
  );

  // Row buffer, two banks
  logic [FW-1:0] ram_rd;

  srs_ram #(.WIDTH(FW), .DEPTH(2 ** AW)) u_ram (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr ({wbank, wpos}),
    .wdata (x),
    .re    (cmd.rd),
    .raddr ({rbank, rpos}),
    .rdata (ram_rd)
  );

  assign rdata = ram_rd;

  // Update terms
  logic signed [DW-1:0] d_up;
  logic                 gt;
  logic [8:0]           e_up;
  logic [8:0]           scale;
  logic [FW+1:0]        sum_raw;
  logic [FW-1:0]        sum_new;

  assign d_up    = gt ? DW'(rmax) - DW'(x) : DW'(x) - DW'(rmax);
  assign gt      = x > rmax;
  assign e_up    = exp_of(d_up);
  assign scale   = gt ? e_up : 9'd256;
  assign sum_raw = {1'b0, prod[FW+8:8]} + (FW+2)'(ev);
  assign sum_new = (sum_raw > (FW+2)'(FMAX)) ? FMAX : sum_raw[FW-1:0];

  // Quotient to float32
  logic [8:0]  q9;
  logic [3:0]  msb;
  logic [31:0] mt;
  logic [31:0] fbits;

  assign q9 = div_q[8:0];

  always_comb begin
    msb = '0;
    for (int i = 0; i < 9; i++) begin
      if (q9[i]) begin
        msb = 4'(i);
      end
    end
    mt    = 32'(q9) << (5'd23 - 5'(msb));
    fbits = (q9 == '0) ? 32'd0 : {1'b0, 8'(msb) + 8'd119, mt[22:0]};
  end

  // Capture request and hold row state
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r       <= op;
      bits_r     <= score_bits;
      can_read_r <= pending != 2'd0;
      masked_r   <= CW'(wpos) >= CW'(valid_tokens);
    end
    if (cmd.chk) begin
      x <= masked_r ? MASKV : '0;
    end
    if (cv_done) begin
      if (bits_r[31]) begin
        x <= (cv_quo > PADW'(QMIN)) ? FMIN : -signed'(cv_quo[FW-1:0]);
      end else begin
        x <= (cv_quo > PADW'(QMAX)) ? FMAX : signed'(cv_quo[FW-1:0]);
      end
    end
    if (cmd.upd) begin
      prod <= rsum * scale;
      ev   <= gt ? 9'd256 : e_up;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rmax       <= MASKV;
      rsum       <= '0;
      wpos       <= '0;
      rpos       <= '0;
      wbank      <= 1'b0;
      rbank      <= 1'b0;
      pending    <= '0;
      row_max[0] <= MASKV;
      row_max[1] <= MASKV;
      row_sum[0] <= '0;
      row_sum[1] <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Raise the running max
      if (cmd.upd && gt) begin
        rmax <= x;
      end
      // Accumulate, close the row at its end
      if (cmd.acc) begin
        if (wpos == LASTP) begin
          wpos           <= '0;
          row_max[wbank] <= rmax;
          row_sum[wbank] <= sum_new;
          rmax           <= MASKV;
          rsum           <= '0;
          wbank          <= ~wbank;
          if (pending != 2'd2) begin
            pending <= pending + 2'd1;
          end
        end else begin
          wpos <= wpos + 1'b1;
          rsum <= sum_new;
        end
      end
      // Advance the read side on emit
      if (cmd.emit) begin
        if (rpos == LASTP) begin
          rpos  <= '0;
          rbank <= ~rbank;
          if (pending != 2'd0) begin
            pending <= pending - 2'd1;
          end
        end else begin
          rpos <= rpos + 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      prob_bits   <= fbits;
      last_in_row <= rpos == LASTP;
    end
  end

  assign stat.is_score  = !op_r;
  assign stat.need_conv = !op_r && !masked_r && !nan;
  assign stat.can_read  = can_read_r;
  assign stat.div_done  = div_done | cv_done;
  assign stat.div_busy  = div_busy | cv_busy;
  assign stat.out_full  = out_valid && !out_ready;
  assign stat.pending   = pending;

endmodule

[rtl/streaming_row_softmax.sv]
// Channel   | Signals                                   | Request carries
// ----------+-------------------------------------------+----------------------------
// input     | in_valid, in_ready                        | op, score_bits
// output    | out_valid, out_ready                      | prob_bits, last_in_row
// config    | psel, penable, pwrite, paddr, pwdata, ... | valid_tokens at 0x0
//
// One request at a time. A score passes through the check, the reciprocal divide
// by SCORE_DIV at 16 bits a cycle and the update and accumulate states; a masked
// or NaN score skips the divide, and a flush goes from check to idle or read.
// A request that emits then reads the row buffer, runs the restoring probability
// division and waits while the output register holds a result not taken.
// Synchronous reset clears control state; the row buffer needs no clearing.
// A new request is taken while a finished result waits in the output register.
module streaming_row_softmax #(
  parameter int ROW_LEN   = 64,
  parameter int SCORE_DIV = 8,
  parameter int FIX_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [31:0] score_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] prob_bits,
  output logic        last_in_row,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import srs_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [6:0] valid_tokens;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_VT) ? {25'd0, valid_tokens} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_tokens <= VT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_VT) begin
      valid_tokens <= pwdata[VT_WIDTH-1:0];
    end
  end

  srs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srs_dp #(
    .ROW_LEN   (ROW_LEN),
    .SCORE_DIV (SCORE_DIV),
    .FIX_WIDTH (FIX_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .score_bits   (score_bits),
    .valid_tokens (valid_tokens),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .prob_bits    (prob_bits),
    .last_in_row  (last_in_row)
  );

  // Only one request is in flight
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // Between requests at most one complete row waits to be read
  a_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> stat.pending != 2'd2)
    else $error("both row banks pending between requests");

  // Divider is idle whenever a new request may enter
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.div_busy)
    else $error("divider busy while idle");

endmodule

[tb/tb_streaming_row_softmax.sv]
module tb_streaming_row_softmax;
  timeunit 1ns;
  timeprecision 1ps;

  import srs_pkg::*;

  localparam int ROW_LEN   = 64;
  localparam int SCORE_DIV = 8;
  localparam int FIX_WIDTH = 16;
  localparam longint FMAX  = (longint'(1) << (FIX_WIDTH - 1)) - 1;
  localparam longint FMIN  = -FMAX - 1;
  localparam longint MASKV = (FIX_WIDTH < 16) ? FMIN : -32768;
  localparam logic OP_SCORE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam logic [2:0] VT_ADDR = 3'd0;

  typedef struct {
    logic [31:0] prob;
    logic        last;
  } prob_t;

  // Softmax predictor with its own row buffer, running values and table
  class prob_predictor;
    longint     row_vals [2*ROW_LEN];
    longint     bank_max [2];
    longint     bank_sum [2];
    longint     run_max;
    longint     run_sum;
    int         wr_pos, rd_pos, wr_bank, rd_bank, full_rows;
    int         tokens;
    logic [15:0] exp_tab [256];
    prob_t      exp_probs [$];

    function new();
      longint unsigned a;
      a = 64'd1 << 32;
      for (int i = 0; i < 256; i++) begin
        exp_tab[i] = 16'((a + (64'd1 << 23)) >> 24);
        a = (a * 64'd4034748382 + (64'd1 << 31)) >> 32;
      end
      for (int i = 0; i < 2*ROW_LEN; i++) row_vals[i] = 0;
      bank_max[0] = MASKV; bank_max[1] = MASKV;
      bank_sum[0] = 0; bank_sum[1] = 0;
      run_max = MASKV; run_sum = 0;
      wr_pos = 0; rd_pos = 0; wr_bank = 0; rd_bank = 0; full_rows = 0;
      tokens = 64;
    endfunction

    function longint clamp(longint v);
      if (v > FMAX) return FMAX;
      if (v < FMIN) return FMIN;
      return v;
    endfunction

    function longint to_fix(logic [31:0] b);
      longint unsigned m, q;
      int sh;
      bit big;
      big = 0;
      q = 0;
      if (b[30:23] == 8'hFF) begin
        if (b[22:0] != 0) return 0;
        big = 1;
      end else begin
        m = (b[30:23] != 0) ? {41'd1, b[22:0]} : {41'd0, b[22:0]};
        sh = ((b[30:23] != 0) ? int'(b[30:23]) : 1) - 142;
        if (m == 0) q = 0;
        else if (sh > 39) big = 1;
        else if (sh >= 0) q = (m << sh) / SCORE_DIV;
        else if (sh <= -40) q = 0;
        else q = m / (longint'(SCORE_DIV) << (-sh));
      end
      if (!b[31]) return (big || q > FMAX) ? FMAX : longint'(q);
      if (big || q > FMAX + 1) return FMIN;
      return -longint'(q);
    endfunction

    function longint exp_of(longint d);
      if (d < EXP_LOW) return exp_tab[255];
      if (d >= 0) return exp_tab[0];
      return exp_tab[((-d) >> 4) & 255];
    endfunction

    function logic [31:0] q_to_float(longint unsigned q);
      int p;
      logic [31:0] mant;
      if (q == 0) return 0;
      p = 63;
      while (q[p] == 0) p--;
      mant = (p >= 23) ? 32'(q >> (p - 23)) : 32'(q << (23 - p));
      return (32'(p - 8 + 127) << 23) | {9'd0, mant[22:0]};
    endfunction

    // Note an accepted request and queue the probability it causes
    function void note(logic op, logic [31:0] bits);
      bit emit;
      longint x, scale, ev;
      longint unsigned e, q;
      prob_t r;
      emit = full_rows != 0;
      if (op == OP_SCORE) begin
        x = (wr_pos < tokens) ? to_fix(bits) : MASKV;
        scale = 256; ev = 256;
        row_vals[wr_bank*ROW_LEN + wr_pos] = x;
        if (x > run_max) begin
          scale = exp_of(run_max - x);
          run_max = x;
        end else begin
          ev = exp_of(x - run_max);
        end
        run_sum = clamp(((run_sum * scale) >>> 8) + ev);
        wr_pos++;
        if (wr_pos >= ROW_LEN) begin
          wr_pos = 0;
          bank_max[wr_bank] = run_max;
          bank_sum[wr_bank] = run_sum;
          run_max = MASKV; run_sum = 0;
          wr_bank ^= 1;
          if (full_rows < 2) full_rows++;
        end
      end
      if (!emit) return;
      e = exp_of(row_vals[rd_bank*ROW_LEN + rd_pos] - bank_max[rd_bank]);
      q = (bank_sum[rd_bank] != 0) ? (e * 256) / bank_sum[rd_bank] : 0;
      r.prob = q_to_float(q);
      r.last = rd_pos == ROW_LEN - 1;
      exp_probs.push_back(r);
      rd_pos++;
      if (rd_pos >= ROW_LEN) begin
        rd_pos = 0;
        rd_bank ^= 1;
        if (full_rows != 0) full_rows--;
      end
    endfunction

    // Compare a result with the oldest expected probability
    function bit check(logic [31:0] prob, logic last, output string msg);
      prob_t r;
      if (exp_probs.size() == 0) begin
        msg = $sformatf("unexpected result prob=%h last=%b", prob, last);
        return 0;
      end
      r = exp_probs.pop_front();
      if (prob !== r.prob || last !== r.last) begin
        msg = $sformatf("prob=%h last=%b, want prob=%h last=%b", prob, last, r.prob, r.last);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic        op = OP_SCORE;
  logic [31:0] score_bits = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] prob_bits;
  logic        last_in_row;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  prob_predictor probs = new();
  int err_cnt = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_go = 0;

  streaming_row_softmax #(.ROW_LEN(ROW_LEN), .SCORE_DIV(SCORE_DIV), .FIX_WIDTH(FIX_WIDTH)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .score_bits(score_bits), .out_valid(out_valid), .out_ready(out_ready),
    .prob_bits(prob_bits), .last_in_row(last_in_row), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Check results before noting requests taken at the same edge
  always @(posedge clk) begin
    string msg;
    if (!rst) begin
      if (out_valid && out_ready && !probs.check(prob_bits, last_in_row, msg))
        report_mismatch(msg);
      if (in_valid && in_ready) probs.note(op, score_bits);
    end
  end

  // Drive receiver readiness, with a long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 0;
      end else begin
        out_ready <= $urandom_range(0, 99) >= recv_stall;
      end
    end
  end

  task automatic send(logic o, logic [31:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid   <= 1;
    op         <= o;
    score_bits <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic apb_write(logic [2:0] a, logic [31:0] d);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (a == VT_ADDR) probs.tokens = d[6:0];
  endtask

  // Wait out every expected result, then the block's own latency
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (probs.exp_probs.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_score();
    logic [31:0] b;
    b = $urandom;
    if ($urandom_range(0, 9) != 0) b[30:23] = 8'($urandom_range(118, 136));
    return b;
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) send(OP_FLUSH, $urandom);
      else send(OP_SCORE, rand_score());
    end
  endtask

  initial begin
    logic [31:0] corner [20];
    corner = '{32'h7F800000, 32'hFF800000, 32'h7FC00001, 32'hFFFFFFFF, 32'h00000001,
               32'h80000000, 32'h00000000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h42000000,
               32'h43800000, 32'h45000000, 32'hC5000000, 32'h3F800000, 32'hBF800000,
               32'h3C000000, 32'h3B800000, 32'hC3000000, 32'h44800000, 32'hC4800000};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    apb_write(VT_ADDR, 64);

    // Directed corners, flush with nothing pending, then complete the row
    send(OP_FLUSH, 32'hFFFFFFFF);
    foreach (corner[i]) send(OP_SCORE, corner[i]);
    send(OP_FLUSH, 0);
    for (int i = 0; i < ROW_LEN - 20; i++) send(OP_SCORE, rand_score());
    send(OP_FLUSH, 0);
    send(OP_FLUSH, 0);
    drain();

    // Phase: no idling, one token, with a long receiver hold-off
    apb_write(VT_ADDR, 1);
    send_idle = 0; recv_stall = 0;
    send_random(150);
    hold_go = 1;
    send_random(190);
    drain();

    // Phase: sender idle, every position masked
    apb_write(VT_ADDR, 0);
    send_idle = 74; recv_stall = 0;
    send_random(330);
    drain();

    // Phase: receiver stalling, full rows, sender pauses halfway
    apb_write(VT_ADDR, 64);
    send_idle = 0; recv_stall = 74;
    send_random(165);
    drain();
    send_random(165);
    drain();

    // Phase: both idle lightly, random token count
    apb_write(VT_ADDR, $urandom_range(2, 63));
    send_idle = 8; recv_stall = 8;
    send_random(250);
    for (int i = 0; i < ROW_LEN + 1; i++) send(OP_FLUSH, $urandom);
    drain();

    if (err_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
